/* design/stma_pkg.sv */
// ----------------------------------------------------------------------------
// stma_pkg
// Shared types and constants for the sparse triplet merge-add block.
// ----------------------------------------------------------------------------
`default_nettype none

package stma_pkg;

  localparam int unsigned StmaListDepth = 32;

  // Item kinds
  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_MERGE  = 2'd2;

  // Result source codes
  localparam logic [1:0] SRC_A   = 2'd0;
  localparam logic [1:0] SRC_B   = 2'd1;
  localparam logic [1:0] SRC_SUM = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         row_res;
    logic [7:0]         col_res;
    logic signed [31:0] value_res;
    logic [1:0]         source;
    logic               last;
  } out_item_t;

  // One stored triplet
  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic clr_counts;
    logic emit;
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic lists_empty;
    logic out_free;
    logic emit_last;
  } dp_sts_t;

endpackage

`default_nettype wire

/* design/stma_ctrl.sv */
// ----------------------------------------------------------------------------
// stma_ctrl
// Sequencer: takes loads in idle, then steps the merge fetch/emit loop.
// ----------------------------------------------------------------------------
`default_nettype none

module stma_ctrl
  import stma_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_kind_i,
  output logic            in_stall_o,
  input  wire dp_sts_t    sts_i,
  output ctl_cmd_t        cmd_o
);

  state_e state_q, state_d;
  logic   idle, merge_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle      = (state_q == ST_IDLE);
  assign merge_acc = idle && in_valid_i && (in_kind_i == KIND_MERGE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (merge_acc && !sts_i.lists_empty) state_d = ST_FETCH;
      end
      ST_FETCH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.emit_last ? ST_IDLE : ST_FETCH;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o        = !idle;
    cmd_o.load_a      = idle && in_valid_i && (in_kind_i == KIND_LOAD_A);
    cmd_o.load_b      = idle && in_valid_i && (in_kind_i == KIND_LOAD_B);
    cmd_o.start       = merge_acc;
    cmd_o.emit        = (state_q == ST_EMIT) && sts_i.out_free;
    cmd_o.clr_counts  = (merge_acc && sts_i.lists_empty) ||
                        (cmd_o.emit && sts_i.emit_last);
  end

endmodule

`default_nettype wire

/* design/stma_dpath.sv */
// ----------------------------------------------------------------------------
// stma_dpath
// List memories, fill counts, merge cursors, key compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stma_dpath
  import stma_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = StmaListDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t in_data_i,
  input  wire ctl_cmd_t cmd_i,
  output dp_sts_t       sts_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CntW-1:0] CntFull = CntW'(LIST_DEPTH);

  entry_t mem_a [LIST_DEPTH];
  entry_t mem_b [LIST_DEPTH];
  entry_t rd_a_q, rd_b_q;
  entry_t wr_entry;

  logic [CntW-1:0] count_a_q, count_b_q;
  logic [CntW-1:0] i_q, j_q, i_d, j_d;
  logic            a_full, b_full, wr_a, wr_b;
  logic            a_has, b_has, a_lt, keys_eq;
  logic            adv_a, adv_b;
  logic [15:0]     key_a, key_b;
  logic            out_valid_q;
  out_item_t       out_q, res;

  assign wr_entry = '{row: in_data_i.row, col: in_data_i.col, value: in_data_i.value};
  assign a_full   = (count_a_q == CntFull);
  assign b_full   = (count_b_q == CntFull);
  assign wr_a     = cmd_i.load_a && !a_full;
  assign wr_b     = cmd_i.load_b && !b_full;

  always_ff @(posedge clk_i) begin
    if (wr_a) mem_a[count_a_q[IdxW-1:0]] <= wr_entry;
    if (wr_b) mem_b[count_b_q[IdxW-1:0]] <= wr_entry;
    rd_a_q <= mem_a[i_q[IdxW-1:0]];
    rd_b_q <= mem_b[j_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q <= '0;
      count_b_q <= '0;
    end else if (cmd_i.clr_counts) begin
      count_a_q <= '0;
      count_b_q <= '0;
    end else begin
      if (wr_a) count_a_q <= count_a_q + CntW'(1);
      if (wr_b) count_b_q <= count_b_q + CntW'(1);
    end
  end

  // Head compare; a cursor that has reached the count means that list is exhausted
  assign a_has   = (i_q < count_a_q);
  assign b_has   = (j_q < count_b_q);
  assign key_a   = {rd_a_q.row, rd_a_q.col};
  assign key_b   = {rd_b_q.row, rd_b_q.col};
  assign a_lt    = (key_a < key_b);
  assign keys_eq = (key_a == key_b);
  assign adv_a   = a_has && (!b_has || a_lt || keys_eq);
  assign adv_b   = b_has && (!a_has || !a_lt);
  assign i_d     = i_q + CntW'(adv_a);
  assign j_d     = j_q + CntW'(adv_b);

  always_comb begin
    res.row_res   = adv_a ? rd_a_q.row : rd_b_q.row;
    res.col_res   = adv_a ? rd_a_q.col : rd_b_q.col;
    res.value_res = rd_a_q.value;
    res.source    = SRC_A;
    if (adv_a && adv_b) begin
      res.value_res = rd_a_q.value + rd_b_q.value;
      res.source    = SRC_SUM;
    end else if (adv_b) begin
      res.value_res = rd_b_q.value;
      res.source    = SRC_B;
    end
    res.last = (i_d == count_a_q) && (j_d == count_b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.start) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.emit) begin
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= res;
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign sts_o.lists_empty = (count_a_q == '0) && (count_b_q == '0);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;
  assign sts_o.emit_last   = res.last;

endmodule

`default_nettype wire

/* design/sparse_triplet_merge_add_top.sv */
// ----------------------------------------------------------------------------
// sparse_triplet_merge_add_top
// Adds two sparse matrices held as row-major (row, col, value) triplet lists.
// ----------------------------------------------------------------------------
// Load beats (kind A or B) are taken one per cycle while no merge runs and
// append a triplet to the chosen list; a load into a full list is dropped. A
// merge beat walks both lists head to head in row-then-column order and emits
// one result per entry, or one per pair where the keys match, summing values
// (wrapping at 32 bits) for such a pair; the final result carries last, and
// both lists are then emptied. Each result is a list read, then a compare and
// register, set by the registered read port of the list memories; in_stall_o
// stays high for the whole merge and any output stall in it. A merge of two
// empty lists is taken without a stall and emits nothing. The result register
// lets the next load be taken while the last result still waits downstream.
`default_nettype none

module sparse_triplet_merge_add_top
  import stma_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = StmaListDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  stma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stma_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* design/stma_checker.sv */
// ----------------------------------------------------------------------------
// stma_checker
// Port-level checks on the merge sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stma_checker
  import stma_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  // Stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // A non-final result means the merge is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input taken before merge finished");

  // Busy only starts from an accepted merge beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && (in_data_i.kind == KIND_MERGE)))
    else $error("busy without merge");

  // New results appear only out of a running merge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result outside merge");

endmodule

bind sparse_triplet_merge_add_top stma_checker u_stma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* dv/sparse_triplet_merge_add_top_tb.sv */
// ----------------------------------------------------------------------------
// sparse_triplet_merge_add_top_tb
// Self-checking bench for the sparse triplet merge-add block.
// ----------------------------------------------------------------------------
// A queue of load and merge beats feeds a falling-edge driver with random
// gaps. Each accepted beat updates a local copy of both triplet lists. On a
// merge, that copy predicts the merged run. A rising-edge monitor checks every
// result beat, field by field, against the oldest prediction. The output
// side stalls at random. Directed corners come first: an empty merge,
// 32-bit wrap, zero sums, single-list tails, unsorted and duplicate keys, and
// the unused kind. Full-list overflow follows, then random sorted sets and noise.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_triplet_merge_add_top_tb;
  import stma_pkg::*;

  localparam int unsigned Depth       = StmaListDepth;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned RandomItems = 130;
  localparam int unsigned DrainCycles = 50;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  always #1 clk_i = ~clk_i;

  sparse_triplet_merge_add_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  in_item_t    pending_items[$];
  out_item_t   merged_expect[$];
  entry_t      list_a_copy[Depth];
  entry_t      list_b_copy[Depth];
  int unsigned fill_a = 0;
  int unsigned fill_b = 0;

  int unsigned issued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned merges_seen  = 0;
  int unsigned err_cnt      = 0;
  int unsigned stim_cnt     = 0;
  int unsigned send_gap     = 0;
  int unsigned send_calm    = 0;
  int unsigned stall_left   = 0;
  int unsigned stall_calm   = 0;
  out_item_t   want_res;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t mk_beat(logic [1:0] kind, logic [7:0] row, logic [7:0] col,
                                       logic [31:0] value);
    in_item_t b;
    b.kind  = kind;
    b.row   = row;
    b.col   = col;
    b.value = value;
    return b;
  endfunction

  task automatic queue_beat(in_item_t b);
    pending_items.push_back(b);
    if (b.kind != KIND_UNUSED) stim_cnt++;
  endtask

  // Sorted set over a shared key range; each key lands in A, B or both.
  task automatic queue_sorted_set(int unsigned nkeys, bit wide);
    in_item_t    qa[$];
    in_item_t    qb[$];
    int unsigned key;
    int unsigned step_max;
    int unsigned k;
    int unsigned pick;
    logic [31:0] va;
    logic [31:0] vb;
    key      = $urandom_range(0, wide ? 4000 : 40);
    step_max = wide ? 1500 : 3;
    for (k = 0; k < nkeys && key <= 16'hFFFF; k++) begin
      pick = $urandom_range(0, 2);
      va   = pick_value();
      vb   = pick_value();
      if (pick == 2 && $urandom_range(0, 2) == 0) vb = -va;
      if (pick != 1) qa.push_back(mk_beat(KIND_LOAD_A, key[15:8], key[7:0], va));
      if (pick != 0) qb.push_back(mk_beat(KIND_LOAD_B, key[15:8], key[7:0], vb));
      key += $urandom_range(1, step_max);
    end
    while (qa.size() != 0 || qb.size() != 0) begin
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 1))
        queue_beat(qa.pop_front());
      else
        queue_beat(qb.pop_front());
    end
    queue_beat(mk_beat(KIND_MERGE, 8'($urandom()), 8'($urandom()), $urandom()));
  endtask

  task automatic queue_noise();
    int unsigned n;
    int unsigned k;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++)
      queue_beat(mk_beat(2'($urandom_range(0, 3)), 8'($urandom()), 8'($urandom()),
                         pick_value()));
  endtask

  task automatic predict_beat(in_item_t b);
    int unsigned i;
    int unsigned j;
    entry_t      ha;
    entry_t      hb;
    out_item_t   res;
    case (b.kind)
      KIND_LOAD_A: begin
        if (fill_a < Depth) begin
          list_a_copy[fill_a] = {b.row, b.col, b.value};
          fill_a++;
        end
      end
      KIND_LOAD_B: begin
        if (fill_b < Depth) begin
          list_b_copy[fill_b] = {b.row, b.col, b.value};
          fill_b++;
        end
      end
      KIND_MERGE: begin
        merges_seen++;
        i = 0;
        j = 0;
        while (i < fill_a || j < fill_b) begin
          ha = list_a_copy[(i < fill_a) ? i : 0];
          hb = list_b_copy[(j < fill_b) ? j : 0];
          if (j >= fill_b || (i < fill_a && {ha.row, ha.col} < {hb.row, hb.col})) begin
            res = {ha.row, ha.col, ha.value, SRC_A, 1'b0};
            i++;
          end else if (i >= fill_a || {ha.row, ha.col} > {hb.row, hb.col}) begin
            res = {hb.row, hb.col, hb.value, SRC_B, 1'b0};
            j++;
          end else begin
            res = {ha.row, hb.col, ha.value + hb.value, SRC_SUM, 1'b0};
            i++;
            j++;
          end
          res.last = (i >= fill_a && j >= fill_b);
          merged_expect.push_back(res);
        end
        fill_a = 0;
        fill_b = 0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || accepted_cnt == issued_cnt) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (pending_items.size() > 0) begin
          in_data_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          issued_cnt++;
          if (send_calm > 0) send_calm--;
          else if ($urandom_range(0, 99) < 4) send_calm = $urandom_range(20, 60);
          else send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (stall_calm > 0) stall_calm--;
        else if ($urandom_range(0, 99) < 5) stall_calm = $urandom_range(20, 80);
        else stall_left = pick_gap();
      end
    end
  end

  // monitor: check result beats, then fold accepted input beats into the copy
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (merged_expect.size() == 0) begin
          $error("unexpected result row_res=%0d col_res=%0d value_res=%0h",
                 out_data_o.row_res, out_data_o.col_res, out_data_o.value_res);
          err_cnt++;
        end else begin
          want_res = merged_expect.pop_front();
          check_field("row_res", 32'(want_res.row_res), 32'(out_data_o.row_res));
          check_field("col_res", 32'(want_res.col_res), 32'(out_data_o.col_res));
          check_field("value_res", want_res.value_res, out_data_o.value_res);
          check_field("source", 32'(want_res.source), 32'(out_data_o.source));
          check_field("last", 32'(want_res.last), 32'(out_data_o.last));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        accepted_cnt++;
        predict_beat(in_data_i);
      end
    end
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned target;
    int unsigned k;
    int unsigned r;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;

    // empty merge: no result at all
    queue_beat(mk_beat(KIND_MERGE, 8'd0, 8'd0, 32'd0));
    // wrap, zero sum from wrap, zero sum, B-only entry in between
    queue_beat(mk_beat(KIND_LOAD_A, 8'd0, 8'd0, 32'h7FFF_FFFF));
    queue_beat(mk_beat(KIND_LOAD_A, 8'd0, 8'd5, 32'd5));
    queue_beat(mk_beat(KIND_LOAD_A, 8'd255, 8'd255, 32'h8000_0000));
    queue_beat(mk_beat(KIND_LOAD_B, 8'd0, 8'd0, 32'd1));
    queue_beat(mk_beat(KIND_LOAD_B, 8'd0, 8'd3, 32'hFFFF_FFFF));
    queue_beat(mk_beat(KIND_LOAD_B, 8'd0, 8'd5, -32'sd5));
    queue_beat(mk_beat(KIND_LOAD_B, 8'd255, 8'd255, 32'h8000_0000));
    queue_beat(mk_beat(KIND_MERGE, 8'd255, 8'd255, 32'hFFFF_FFFF));
    // A only, with a zero value
    queue_beat(mk_beat(KIND_LOAD_A, 8'd3, 8'd4, 32'hFFFF_FFFF));
    queue_beat(mk_beat(KIND_LOAD_A, 8'd200, 8'd1, 32'd0));
    queue_beat(mk_beat(KIND_MERGE, 8'd0, 8'd0, 32'd0));
    // B only
    queue_beat(mk_beat(KIND_LOAD_B, 8'd1, 8'd1, 32'hFFFF_FFFF));
    queue_beat(mk_beat(KIND_MERGE, 8'd0, 8'd0, 32'd0));
    // unsorted A with a duplicate key
    queue_beat(mk_beat(KIND_LOAD_A, 8'd9, 8'd9, 32'd1));
    queue_beat(mk_beat(KIND_LOAD_A, 8'd2, 8'd2, 32'd2));
    queue_beat(mk_beat(KIND_LOAD_A, 8'd2, 8'd2, 32'd3));
    queue_beat(mk_beat(KIND_LOAD_B, 8'd2, 8'd2, 32'd10));
    queue_beat(mk_beat(KIND_LOAD_B, 8'd9, 8'd9, 32'd20));
    queue_beat(mk_beat(KIND_MERGE, 8'd0, 8'd0, 32'd0));
    // unused kind must not load
    queue_beat(mk_beat(KIND_LOAD_A, 8'd4, 8'd4, 32'd4));
    queue_beat(mk_beat(KIND_UNUSED, 8'd4, 8'd4, 32'd100));
    queue_beat(mk_beat(KIND_MERGE, 8'd0, 8'd0, 32'd0));

    target = RandomItems;
    // both lists pushed past full, longest merged run
    for (k = 0; k < Depth + 1; k++) begin
      queue_beat(mk_beat(KIND_LOAD_A, 8'(k * 7), 8'($urandom_range(0, 3)), pick_value()));
      queue_beat(mk_beat(KIND_LOAD_B, 8'(k * 7), 8'($urandom_range(0, 3)), pick_value()));
    end
    queue_beat(mk_beat(KIND_MERGE, 8'd0, 8'd0, 32'd0));

    while (stim_cnt < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) queue_sorted_set($urandom_range(1, 10), $urandom_range(0, 3) == 0);
      else if (r < 88) queue_noise();
      else if (r < 95)
        queue_beat(mk_beat(KIND_MERGE, 8'($urandom()), 8'($urandom()), $urandom()));
      else queue_sorted_set($urandom_range(20, 32), 1'b1);
    end
    queue_beat(mk_beat(KIND_MERGE, 8'd0, 8'd0, 32'd0));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || accepted_cnt != issued_cnt || in_valid_i)
      @(posedge clk_i);
    while (merged_expect.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run: %0d beats accepted, %0d merges, %0d results checked",
             accepted_cnt, merges_seen, results_seen);
    $display("run: corners, sorted and unsorted sets, noise and full lists covered");
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
